// ===== src/percent_codec_stream_assert.svh =====
// assertion helpers, used where clk and rst_n are in scope
`ifndef PERCENT_CODEC_STREAM_ASSERT_SVH
`define PERCENT_CODEC_STREAM_ASSERT_SVH

// condition holds at every edge out of reset
`define PCS_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// condition on one edge implies a condition on the next
`define PCS_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/pcs_pkg.sv =====
package pcs_pkg;

    // mode register codes, code 3 behaves as plain encode
    localparam logic [1:0] MODE_ENCODE = 2'd0;
    localparam logic [1:0] MODE_PATH   = 2'd1;
    localparam logic [1:0] MODE_DECODE = 2'd2;

    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_TILDE     = 8'h7E;
    localparam logic [7:0] CH_HYPHEN    = 8'h2D;
    localparam logic [7:0] CH_UNDERLINE = 8'h5F;
    localparam logic [7:0] CH_DOT       = 8'h2E;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        ESC_NONE  = 3'b001,
        ESC_PCT   = 3'b010,
        ESC_DIGIT = 3'b100
    } esc_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    // one accepted byte's worth of results
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      num;
        logic            present;
        logic            last;
    } pcs_group_t;

    typedef struct packed {
        logic       en;
        pcs_group_t group;
    } pcs_push_t;

    typedef struct packed {
        logic       valid;
        pcs_group_t group;
    } pcs_head_t;

    function automatic hex_t hex_val(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b0;
        h.val = c[3:0];
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.ok = 1'b1;
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            h.ok  = 1'b1;
            h.val = c[3:0] + 4'd9;
        end
        return h;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10)
        begin
            r = 8'h30 + {4'h0, nib};
        end
        else
        begin
            r = 8'h37 + {4'h0, nib};
        end
        return r;
    endfunction

    function automatic logic is_unreserved(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || c == CH_HYPHEN || c == CH_UNDERLINE ||
               c == CH_DOT || c == CH_TILDE;
    endfunction

endpackage

// ===== src/pcs_channels.sv =====
interface pcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_present;
    logic       out_last;

    modport source (output valid, output out_byte, output byte_present, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_present, input out_last,
                    output ready);
endinterface

interface pcs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;

    modport source (output valid, output mode, input ready);
    modport sink   (input valid, input mode, output ready);
endinterface

// ===== src/percent_codec_stream.sv =====
// percent_codec_stream: streaming percent encoder / decoder for uri text
//
// in_ch   : one request per string byte (in_byte, in_last on the final byte)
// out_ch  : result bytes (out_byte, byte_present, out_last on the final one);
//           a string whose final byte yields nothing ends with an empty marker
// cfg_ch  : mode writes (0 encode, 1 path normalise and encode, 2 decode),
//           always ready, only to be written while the block is idle
//
// path    : a taken request's group is written into the queue, and the back then
//           loads its first byte into the output register that drives out_ch
// rate    : one byte per cycle in (while the queue is not full) and out (while
//           out_ch.ready holds); an encoded byte gives three result bytes, so the
//           output port (one byte per cycle) sets the pace and the four-group queue backs up into in_ch.ready
// reset   : rst_n clears mode to encode, drops any pending escape and empties
//           the queue and output register
// stalls  : a stalled receiver holds the output register, the queue fills and
//           in_ch.ready falls; nothing is lost or repeated
module percent_codec_stream (
    input  logic       clk,
    input  logic       rst_n,
    pcs_in_if.sink     in_ch,
    pcs_out_if.source  out_ch,
    pcs_cfg_if.sink    cfg_ch
);
    import pcs_pkg::*;

    // front to queue: a group of up to three result bytes per request
    pcs_push_t push;
    // queue to back: oldest group still being emitted
    pcs_head_t head;
    logic      q_full;
    logic      pop;

    // front: mode register, escape state, classification of each byte
    pcs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .q_full (q_full),
        .push   (push)
    );

    // short queue so front and back stall independently
    pcs_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    // back: serialises each group one byte per cycle, while out_ch is not stalled, into the output register
    pcs_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

// ===== src/pcs_front.sv =====
`include "percent_codec_stream_assert.svh"

module pcs_front (
    input  logic              clk,
    input  logic              rst_n,
    pcs_in_if.sink            in_ch,
    pcs_cfg_if.sink           cfg_ch,
    input  logic              q_full,
    output pcs_pkg::pcs_push_t push
);
    import pcs_pkg::*;

    logic [1:0] mode_reg;
    esc_t       esc_reg, esc_next;
    logic [7:0] held_reg, held_next;
    logic       at_start_reg, at_start_next;

    logic [2:0][7:0] res;
    logic [1:0]      n;
    logic [7:0]      c;
    hex_t            hv, hh;
    logic            open_plain;
    logic            accept;

    assign in_ch.ready  = !q_full;
    assign cfg_ch.ready = 1'b1;
    assign accept       = in_ch.valid && in_ch.ready;

    always_comb
    begin
        res           = '0;
        n             = 2'd0;
        esc_next      = esc_reg;
        held_next     = held_reg;
        at_start_next = at_start_reg;
        c             = in_ch.in_byte;
        hv            = hex_val(in_ch.in_byte);
        hh            = hex_val(held_reg);
        open_plain    = 1'b0;

        if (mode_reg == MODE_DECODE)
        begin
            at_start_next = 1'b0;
            unique case (esc_reg)
                ESC_PCT:
                begin
                    if (hv.ok)
                    begin
                        held_next = c;
                        esc_next  = ESC_DIGIT;
                    end
                    else
                    begin
                        esc_next   = ESC_NONE;
                        res[n]     = CH_PERCENT;
                        n          = n + 2'd1;
                        open_plain = 1'b1;
                    end
                end
                ESC_DIGIT:
                begin
                    esc_next = ESC_NONE;
                    if (hv.ok && hh.ok)
                    begin
                        res[n] = {hh.val, hv.val};
                        n      = n + 2'd1;
                    end
                    else
                    begin
                        res[n]     = CH_PERCENT;
                        n          = n + 2'd1;
                        res[n]     = held_reg;
                        n          = n + 2'd1;
                        open_plain = 1'b1;
                    end
                end
                ESC_NONE:
                begin
                    open_plain = 1'b1;
                end
                default:
                begin
                    esc_next   = ESC_NONE;
                    open_plain = 1'b1;
                end
            endcase
            if (open_plain)
            begin
                if (c == CH_PERCENT)
                begin
                    esc_next = ESC_PCT;
                end
                else
                begin
                    res[n] = c;
                    n      = n + 2'd1;
                end
            end
        end
        else
        begin
            esc_next = ESC_NONE;
            if (mode_reg == MODE_PATH && c == CH_BACKSLASH)
            begin
                c = CH_SLASH;
            end
            // leading slashes of a path are dropped
            if (!(mode_reg == MODE_PATH && at_start_reg && c == CH_SLASH))
            begin
                at_start_next = 1'b0;
                if (is_unreserved(c) ||
                    (mode_reg == MODE_PATH && (c == CH_SLASH || c == CH_COLON)))
                begin
                    res[n] = c;
                    n      = n + 2'd1;
                end
                else
                begin
                    res[0] = CH_PERCENT;
                    res[1] = hex_char(c[7:4]);
                    res[2] = hex_char(c[3:0]);
                    n      = 2'd3;
                end
            end
        end

        // end of string flushes a pending escape literally
        if (in_ch.in_last)
        begin
            if (esc_next == ESC_PCT)
            begin
                res[n] = CH_PERCENT;
                n      = n + 2'd1;
            end
            else if (esc_next == ESC_DIGIT)
            begin
                res[n] = CH_PERCENT;
                n      = n + 2'd1;
                res[n] = held_next;
                n      = n + 2'd1;
            end
            esc_next      = ESC_NONE;
            held_next     = 8'h00;
            at_start_next = 1'b1;
        end
    end

    assign push.en            = accept && (n != 2'd0 || in_ch.in_last);
    assign push.group.data    = res;
    assign push.group.num     = (n == 2'd0) ? 2'd1 : n;
    assign push.group.present = (n != 2'd0);
    assign push.group.last    = in_ch.in_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_ENCODE;
            esc_reg      <= ESC_NONE;
            held_reg     <= 8'h00;
            at_start_reg <= 1'b1;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                mode_reg <= cfg_ch.mode;
            end
            if (accept)
            begin
                esc_reg      <= esc_next;
                held_reg     <= held_next;
                at_start_reg <= at_start_next;
            end
        end
    end

    `PCS_ASSERT_NEXT(a_end_clears_state, accept && in_ch.in_last, esc_reg == ESC_NONE && at_start_reg && held_reg == 8'h00, "string end left escape state behind")
    `PCS_ASSERT_ALWAYS(a_empty_only_at_end, !push.en || push.group.present || push.group.last, "empty group pushed mid string")

endmodule

// ===== src/pcs_fifo.sv =====
`include "percent_codec_stream_assert.svh"

module pcs_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  pcs_pkg::pcs_push_t push,
    input  logic               pop,
    output logic               full,
    output pcs_pkg::pcs_head_t head
);
    import pcs_pkg::*;

    pcs_group_t         mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_pop;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.group = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        count_next = count_reg;
        if (push.en && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.en && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.en)
        begin
            mem_reg[wr_ptr_reg] <= push.group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `PCS_ASSERT_ALWAYS(a_no_overflow, !(push.en && full), "group pushed into full queue")
    `PCS_ASSERT_ALWAYS(a_count_bound, count_reg <= Q_CNT_W'(Q_DEPTH), "queue count beyond depth")

endmodule

// ===== src/pcs_back.sv =====
`include "percent_codec_stream_assert.svh"

module pcs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  pcs_pkg::pcs_head_t head,
    output logic               pop,
    pcs_out_if.source          out_ch
);
    import pcs_pkg::*;

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       present_reg;
    logic       last_reg;
    logic       load;
    logic       final_one;

    assign load      = head.valid && (!valid_reg || out_ch.ready);
    assign final_one = (idx_reg == head.group.num - 2'd1);
    assign pop       = load && final_one;

    assign out_ch.valid        = valid_reg;
    assign out_ch.out_byte     = byte_reg;
    assign out_ch.byte_present = present_reg;
    assign out_ch.out_last     = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg    <= head.group.data[idx_reg];
            present_reg <= head.group.present;
            last_reg    <= head.group.last && final_one;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= final_one ? 2'd0 : idx_reg + 2'd1;
            end
            else if (out_ch.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    `PCS_ASSERT_ALWAYS(a_idx_in_group, !head.valid || idx_reg < head.group.num, "byte index past group size")
    `PCS_ASSERT_ALWAYS(a_idx_idle_zero, head.valid || idx_reg == 2'd0, "byte index left over with queue empty")

endmodule
